// File: hw/rtl/loop_branch_trip_predictor_update_core_defines.svh
// Assertion macros for the loop trip predictor update core.
`ifndef LOOP_BRANCH_TRIP_PREDICTOR_UPDATE_CORE_DEFINES_SVH
`define LOOP_BRANCH_TRIP_PREDICTOR_UPDATE_CORE_DEFINES_SVH

// plain property, checked every cycle out of reset
`define LBTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define LBTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lbtp_pkg.sv
// Types and constants shared by the loop trip predictor update core.
package lbtp_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned LIM_W  = 4;
  localparam int unsigned APB_AW = 2;
  localparam int unsigned APB_DW = 32;

  localparam logic [APB_AW-1:0] REG_QUEUE_LIMIT = 2'd0;
  localparam logic [LIM_W-1:0]  QUEUE_LIMIT_RST = 4'd8;
  localparam logic [CNT_W-1:0]  COUNT_MAX       = 16'hFFFF;

  typedef enum logic [ST_W-1:0] {
    ST_ALLOC = 3'd0,
    ST_INC   = 3'd1,
    ST_TRIP  = 3'd2,
    ST_MISS  = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic [ADDR_W-1:0] target_address;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] iteration_count;
    logic [CNT_W-1:0] trip_total;
    logic             inner_taken;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] tag;
    logic [CNT_W-1:0]  iterations;
    logic [CNT_W-1:0]  trips;
    logic              inner_mark;
  } entry_t;

endpackage

// File: hw/rtl/loop_branch_trip_predictor_update_core.sv
// Loop trip predictor update core: table scan, loop queue scan/pop, table update.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------
//   in       | input     | in_valid_i/in_ready_o | in_item_t  (in_data_i)
//   out      | output    | out_valid_o/out_ready_i | out_item_t (out_data_o)
//   apb      | input     | psel/penable/pready   | queue_limit at 0x0
//
// An update scans the entry table; on a table hit with a non-empty loop queue
// it then scans the queue, and it pops queued addresses above the branch
// address before the table update.
// The entry table has one read port and is scanned one entry per cycle; the
// loop queue is read one address per cycle.
// Reset clears the valid bits and queue count at once; no clearing pass.
// A held result stalls only the last step; a new update is taken once the
// result moves into the output register.
`include "loop_branch_trip_predictor_update_core_defines.svh"

module loop_branch_trip_predictor_update_core
  import lbtp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned QUEUE_DEPTH   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned TW = $clog2(TABLE_ENTRIES);
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [TW-1:0] TLAST = TW'(TABLE_ENTRIES - 1);
  localparam logic [QW:0]   QD_W  = (QW+1)'(QUEUE_DEPTH);
  localparam logic [7:0]    QD8   = 8'(QUEUE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_TSCAN  = 9'b000000010,
    S_TDRAIN = 9'b000000100,
    S_QSCAN  = 9'b000001000,
    S_QDRAIN = 9'b000010000,
    S_POPRD  = 9'b000100000,
    S_POPCMP = 9'b001000000,
    S_UPDATE = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_e;

  function automatic logic [QW-1:0] qwrap(input logic [QW:0] s);
    logic [QW:0] r;
    r = (s >= QD_W) ? (s - QD_W) : s;
    return r[QW-1:0];
  endfunction

  state_e                   state_q, state_d;
  in_item_t                 item_q, item_d;
  logic [TW-1:0]            tidx_q, tidx_d;
  logic                     tcmp_q, tcmp_d;
  logic [TW-1:0]            tcidx_q, tcidx_d;
  logic                     hit_q, hit_d;
  logic [TW-1:0]            hidx_q, hidx_d;
  entry_t                   hrec_q, hrec_d;
  logic                     free_q, free_d;
  logic [TW-1:0]            fidx_q, fidx_d;
  logic [CW-1:0]            qi_q, qi_d;
  logic                     qcmp_q, qcmp_d;
  logic [QW-1:0]            head_q, head_d;
  logic [CW-1:0]            rcnt_q, rcnt_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [LIM_W-1:0]         limit_q, limit_d;
  out_item_t                res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_data_q, out_data_d;

  entry_t                   entry_mem [TABLE_ENTRIES];
  entry_t                   ent_rd_q;
  logic                     ent_we;
  logic [TW-1:0]            ent_wa;
  entry_t                   ent_wd;

  logic [ADDR_W-1:0]        queue_mem [QUEUE_DEPTH];
  logic [ADDR_W-1:0]        q_rd_q;
  logic                     q_we;
  logic [QW-1:0]            q_wa;
  logic [QW-1:0]            q_ra;

  logic                     taken;
  logic                     cfg_wr;
  logic [7:0]               cfg8;
  logic [7:0]               lim8;
  logic [CW-1:0]            lim;
  logic [CW-1:0]            ndrop;
  logic [QW-1:0]            head1;
  logic [CW-1:0]            cnt1;
  entry_t                   rec;

  assign taken  = item_q.target_address < item_q.branch_address;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_QUEUE_LIMIT);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_QUEUE_LIMIT) ? {{(APB_DW-LIM_W){1'b0}}, limit_q} : '0;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // effective queue limit: 0 acts as 1, clipped to the queue depth
  assign cfg8 = {4'b0, limit_q};
  assign lim8 = (cfg8 == 8'd0) ? 8'd1 : ((cfg8 > QD8) ? QD8 : cfg8);
  assign lim  = lim8[CW-1:0];

  always_comb begin
    if (rcnt_q >= lim) begin
      ndrop = rcnt_q - lim + CW'(1);
      head1 = qwrap({1'b0, head_q} + (QW+1)'(ndrop));
      cnt1  = lim - CW'(1);
    end else begin
      ndrop = '0;
      head1 = head_q;
      cnt1  = rcnt_q;
    end
  end

  always_comb begin
    unique case (state_q)
      S_POPRD: q_ra = qwrap({1'b0, head_q} + (QW+1)'(rcnt_q - CW'(1)));
      default: q_ra = qwrap({1'b0, head_q} + (QW+1)'(qi_q));
    endcase
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    tidx_d      = tidx_q;
    tcmp_d      = 1'b0;
    tcidx_d     = tcidx_q;
    hit_d       = hit_q;
    hidx_d      = hidx_q;
    hrec_d      = hrec_q;
    free_d      = free_q;
    fidx_d      = fidx_q;
    qi_d        = qi_q;
    qcmp_d      = 1'b0;
    head_d      = head_q;
    rcnt_d      = rcnt_q;
    valid_d     = valid_q;
    limit_d     = cfg_wr ? pwdata[LIM_W-1:0] : limit_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ent_we      = 1'b0;
    ent_wa      = hidx_q;
    ent_wd      = hrec_q;
    q_we        = 1'b0;
    q_wa        = '0;
    rec         = hrec_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // table compare, one entry behind the read
    if (tcmp_q) begin
      if (valid_q[tcidx_q]) begin
        if (!hit_q && ent_rd_q.tag == item_q.branch_address) begin
          hit_d  = 1'b1;
          hidx_d = tcidx_q;
          hrec_d = ent_rd_q;
        end
      end else if (!free_q) begin
        free_d = 1'b1;
        fidx_d = tcidx_q;
      end
    end

    // queued branch inside [target, branch)
    if (qcmp_q && q_rd_q >= item_q.target_address && q_rd_q < item_q.branch_address) begin
      hrec_d.inner_mark = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          tidx_d  = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = S_TSCAN;
        end
      end
      S_TSCAN: begin
        tcmp_d  = 1'b1;
        tcidx_d = tidx_q;
        if (tidx_q == TLAST) begin
          state_d = S_TDRAIN;
        end else begin
          tidx_d = tidx_q + TW'(1);
        end
      end
      S_TDRAIN: begin
        qi_d = '0;
        if (hit_d && rcnt_q != '0) begin
          state_d = S_QSCAN;
        end else begin
          state_d = S_POPRD;
        end
      end
      S_QSCAN: begin
        qcmp_d = 1'b1;
        if (qi_q == rcnt_q - CW'(1)) begin
          state_d = S_QDRAIN;
        end else begin
          qi_d = qi_q + CW'(1);
        end
      end
      S_QDRAIN: begin
        state_d = S_POPRD;
      end
      S_POPRD: begin
        state_d = (rcnt_q == '0) ? S_UPDATE : S_POPCMP;
      end
      S_POPCMP: begin
        if (q_rd_q > item_q.branch_address) begin
          rcnt_d  = rcnt_q - CW'(1);
          state_d = S_POPRD;
        end else begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (taken) begin
          head_d = head1;
          rcnt_d = cnt1 + CW'(1);
          q_we   = 1'b1;
          q_wa   = qwrap({1'b0, head1} + (QW+1)'(cnt1));
        end
        if (hit_q) begin
          if (taken) begin
            if (rec.iterations != COUNT_MAX) begin
              rec.iterations = rec.iterations + CNT_W'(1);
            end
            res_d.status = ST_INC;
          end else begin
            rec.trips      = rec.iterations;
            rec.iterations = '0;
            res_d.status   = ST_TRIP;
          end
          ent_we                = 1'b1;
          ent_wa                = hidx_q;
          ent_wd                = rec;
          res_d.iteration_count = rec.iterations;
          res_d.trip_total      = rec.trips;
          res_d.inner_taken     = rec.inner_mark;
        end else if (taken && free_q) begin
          rec.tag               = item_q.branch_address;
          rec.iterations        = CNT_W'(1);
          rec.trips             = '0;
          rec.inner_mark        = 1'b0;
          ent_we                = 1'b1;
          ent_wa                = fidx_q;
          ent_wd                = rec;
          valid_d[fidx_q]       = 1'b1;
          res_d.status          = ST_ALLOC;
          res_d.iteration_count = rec.iterations;
          res_d.trip_total      = rec.trips;
          res_d.inner_taken     = rec.inner_mark;
        end else begin
          res_d.status          = taken ? ST_FULL : ST_MISS;
          res_d.iteration_count = '0;
          res_d.trip_total      = '0;
          res_d.inner_taken     = 1'b0;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tcmp_q      <= 1'b0;
      qcmp_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      head_q      <= '0;
      rcnt_q      <= '0;
      valid_q     <= '0;
      limit_q     <= QUEUE_LIMIT_RST;
      out_valid_q <= 1'b0;
      tidx_q      <= '0;
      qi_q        <= '0;
    end else begin
      state_q     <= state_d;
      tcmp_q      <= tcmp_d;
      qcmp_q      <= qcmp_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      head_q      <= head_d;
      rcnt_q      <= rcnt_d;
      valid_q     <= valid_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      tidx_q      <= tidx_d;
      qi_q        <= qi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    tcidx_q    <= tcidx_d;
    hidx_q     <= hidx_d;
    hrec_q     <= hrec_d;
    fidx_q     <= fidx_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      entry_mem[ent_wa] <= ent_wd;
    end
    ent_rd_q <= entry_mem[tidx_q];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[q_wa] <= item_q.branch_address;
    end
    q_rd_q <= queue_mem[q_ra];
  end

  logic in_xfer;
  logic out_alloc;
  logic alloc_ok;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_alloc = out_valid_o && (out_data_o.status == ST_ALLOC);
  assign alloc_ok  = (out_data_o.iteration_count == CNT_W'(1)) &&
                     (out_data_o.trip_total == '0) && !out_data_o.inner_taken;

  `LBTP_ASSERT(a_qcnt_bound, rcnt_q <= CW'(QUEUE_DEPTH), "loop queue count above depth")
  `LBTP_ASSERT_NEXT(a_busy_after_in, in_xfer, !in_ready_o, "ready right after transfer")
  `LBTP_ASSERT_IMP(a_status_code, out_valid_o, out_data_o.status <= ST_FULL, "bad status code")
  `LBTP_ASSERT_IMP(a_alloc_fields, out_alloc, alloc_ok, "bad fields on allocation")
  `LBTP_ASSERT_IMP(a_pop_guard, state_q == S_POPCMP, rcnt_q != '0, "pop compare on empty queue")

endmodule

// File: sim/loop_branch_trip_predictor_update_core_tb.sv
// Testbench for the loop trip predictor update core: directed and random checks.
`timescale 1ns / 100ps

module loop_branch_trip_predictor_update_core_tb;
  import lbtp_pkg::*;

  localparam int TBL_N      = 16;
  localparam int QDEPTH     = 8;
  localparam int LOOPS      = 8;
  localparam int RX_HOLD    = 300;
  localparam int QUIET_MAX  = 3000;
  localparam int PHASE_LEN  = 225;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  loop_branch_trip_predictor_update_core #(
    .TABLE_ENTRIES(TBL_N),
    .QUEUE_DEPTH  (QDEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor state
  logic              loop_valid [TBL_N];
  entry_t            loop_entry [TBL_N];
  logic [ADDR_W-1:0] recent_loops [QDEPTH];
  int unsigned       recent_n;
  logic [LIM_W-1:0]  queue_limit_cfg;

  out_item_t   expected_updates [$];
  int          mismatch_count = 0;
  int unsigned updates_sent   = 0;
  logic        idle_on        = 1'b0;
  int          hold_req       = 0;
  int          hold_ack       = 0;
  int          hold_left      = 0;
  int          burst_left     = 0;
  int          quiet_cycles   = 0;
  out_item_t   want_update;

  logic [ADDR_W-1:0] pool_br [LOOPS];
  logic [ADDR_W-1:0] pool_tg [LOOPS];

  function automatic out_item_t predict_update(input in_item_t upd);
    logic [ADDR_W-1:0] br;
    logic [ADDR_W-1:0] tg;
    logic              found;
    int                hit;
    int                free_slot;
    int unsigned       lim;
    status_e           st;
    out_item_t         res;
    br = upd.branch_address;
    tg = upd.target_address;
    hit = -1;
    free_slot = -1;
    found = 1'b0;
    for (int i = 0; i < TBL_N; i++) begin
      if (loop_valid[i]) begin
        if (hit < 0 && loop_entry[i].tag == br) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit >= 0) begin
      for (int q = 0; q < recent_n; q++) begin
        if (!found && recent_loops[q] >= tg && recent_loops[q] < br) found = 1'b1;
      end
      if (found) loop_entry[hit].inner_mark = 1'b1;
    end
    while (recent_n > 0 && recent_loops[recent_n-1] > br) recent_n--;
    if (tg < br) begin
      lim = (queue_limit_cfg == 0) ? 1 : (queue_limit_cfg > QDEPTH) ? QDEPTH : queue_limit_cfg;
      if (hit >= 0) begin
        if (loop_entry[hit].iterations != COUNT_MAX)
          loop_entry[hit].iterations = loop_entry[hit].iterations + 1'b1;
        st = ST_INC;
      end else if (free_slot >= 0) begin
        hit = free_slot;
        loop_valid[hit] = 1'b1;
        loop_entry[hit].tag = br;
        loop_entry[hit].iterations = CNT_W'(1);
        loop_entry[hit].trips = '0;
        loop_entry[hit].inner_mark = 1'b0;
        st = ST_ALLOC;
      end else begin
        st = ST_FULL;
      end
      while (recent_n >= lim) begin
        for (int j = 1; j < recent_n; j++) recent_loops[j-1] = recent_loops[j];
        recent_n--;
      end
      recent_loops[recent_n] = br;
      recent_n++;
    end else begin
      if (hit >= 0) begin
        loop_entry[hit].trips = loop_entry[hit].iterations;
        loop_entry[hit].iterations = '0;
        st = ST_TRIP;
      end else begin
        st = ST_MISS;
      end
    end
    res = '0;
    res.status = st;
    if (hit >= 0) begin
      res.iteration_count = loop_entry[hit].iterations;
      res.trip_total      = loop_entry[hit].trips;
      res.inner_taken     = loop_entry[hit].inner_mark;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_updates.size() == 0) begin
        report_mismatch("unexpected transfer", out_data_o, '0);
      end else begin
        want_update = expected_updates[0];
        expected_updates.delete(0);
        if (out_data_o.status !== want_update.status)
          report_mismatch("status", out_data_o.status, want_update.status);
        if (out_data_o.iteration_count !== want_update.iteration_count)
          report_mismatch("iteration_count", out_data_o.iteration_count,
                          want_update.iteration_count);
        if (out_data_o.trip_total !== want_update.trip_total)
          report_mismatch("trip_total", out_data_o.trip_total, want_update.trip_total);
        if (out_data_o.inner_taken !== want_update.inner_taken)
          report_mismatch("inner_taken", out_data_o.inner_taken, want_update.inner_taken);
      end
    end
  end

  // receiver: long hold on request, else short random stalls
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= RX_HOLD;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left  <= burst_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      burst_left  <= $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_update(input logic [ADDR_W-1:0] br, input logic [ADDR_W-1:0] tg);
    in_item_t  upd;
    out_item_t want;
    upd.branch_address = br;
    upd.target_address = tg;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= upd;
    do @(posedge clk_i); while (!in_ready_o);
    want = predict_update(upd);
    expected_updates.insert(expected_updates.size(), want);
    updates_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_queue_limit(input logic [LIM_W-1:0] lim);
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_QUEUE_LIMIT;
    pwdata  <= APB_DW'(lim);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    queue_limit_cfg = lim;
    @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom};
  endfunction

  // nested loop run: inner body iterations per outer iteration, then exit
  task automatic run_loop_nest();
    int o;
    int i;
    o = $urandom_range(0, LOOPS-2);
    i = $urandom_range(o+1, LOOPS-1);
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, 5)) send_update(pool_br[i], pool_tg[i]);
      send_update(pool_br[i], pool_br[i] + 4);
      send_update(pool_br[o], pool_tg[o]);
    end
    send_update(pool_br[o], pool_br[o] + 4);
  endtask

  task automatic test_directed();
    send_update(48'h1000, 48'h2000);
    send_update(48'h1000, 48'h1000);
    send_update(48'h1100, 48'h1000);
    send_update(48'h1100, 48'h1000);
    send_update(48'h1050, 48'h1020);
    send_update(48'h1050, 48'h1020);
    send_update(48'h1050, 48'h1054);
    send_update(48'h1100, 48'h1000);
    send_update(48'h1100, 48'h1104);
    send_update(48'h1200, 48'h0);
    send_update(ADDR_MAX, 48'h0);
    send_update(ADDR_MAX, ADDR_MAX);
    send_update(48'h0, ADDR_MAX);
    send_update(48'h1, 48'h0);
    send_update(48'h0, 48'h0);
    send_update(48'h0, 48'h0);
    send_update(48'h1, 48'h0);
    send_update(ADDR_MAX, 48'h0);
    send_update(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    send_update(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    wait_drained();
  endtask

  task automatic test_queue_limit();
    write_queue_limit(4'd8);
    for (int k = LOOPS-1; k >= 0; k--) send_update(pool_br[k], pool_tg[k]);
    send_update(pool_br[0], pool_tg[0]);
    write_queue_limit(4'd2);
    send_update(pool_br[0], pool_tg[0]);
    send_update(pool_br[1], pool_br[1] + 4);
    write_queue_limit(4'd0);
    for (int k = LOOPS-1; k >= 4; k--) send_update(pool_br[k], pool_tg[k]);
    write_queue_limit(4'd15);
    for (int k = LOOPS-1; k >= 0; k--) send_update(pool_br[k], pool_tg[k]);
    send_update(pool_br[0], pool_tg[0]);
    send_update(pool_br[0], pool_br[0] + 4);
    wait_drained();
  endtask

  task automatic test_backpressure();
    int k;
    write_queue_limit(4'd4);
    hold_req <= hold_req + 1;
    repeat (16) begin
      k = $urandom_range(0, LOOPS-1);
      if ($urandom_range(0, 3) == 0) send_update(pool_br[k], pool_br[k] + 4);
      else send_update(pool_br[k], pool_tg[k]);
    end
    wait_drained();
  endtask

  task automatic test_random_loops();
    logic [LIM_W-1:0] limits [6];
    int unsigned      phase_end;
    int               k;
    logic [ADDR_W-1:0] br;
    logic [ADDR_W-1:0] tg;
    limits = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd6};
    for (int p = 0; p < 6; p++) begin
      write_queue_limit(limits[p]);
      idle_on <= (p % 3 != 2);
      phase_end = updates_sent + PHASE_LEN;
      while (updates_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            br = rand_addr();
            tg = rand_addr();
            send_update(br, tg);
          end
          2: begin
            k = $urandom_range(0, LOOPS-1);
            if ($urandom_range(0, 1) == 0) send_update(pool_br[k], pool_tg[k]);
            else send_update(pool_br[k], rand_addr());
          end
          default: run_loop_nest();
        endcase
      end
      wait_drained();
    end
    idle_on <= 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] base;
    for (int i = 0; i < TBL_N; i++) loop_valid[i] = 1'b0;
    recent_n = 0;
    queue_limit_cfg = QUEUE_LIMIT_RST;
    base = {16'($urandom_range(0, 16'hFFFE)), $urandom} & 48'hFFFF_FFFF_0000;
    for (int k = 0; k < LOOPS; k++) begin
      pool_tg[k] = base + k * 48'h40 + $urandom_range(0, 15);
      pool_br[k] = base + 48'h1000 - k * 48'h40 - $urandom_range(0, 15);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_queue_limit();
    test_backpressure();
    test_random_loops();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && expected_updates.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
